>>> rtl/ied_pkg.sv
package ied_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIST_WIDTH  = 17;

   // Pipeline control handed from the top level to every stage.
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

endpackage

>>> rtl/ied_req_if.sv
interface ied_req_if #(
   parameter int COORD_WIDTH = ied_pkg::COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;

   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

>>> rtl/ied_rsp_if.sv
interface ied_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ied_pkg::DIST_WIDTH-1:0]  distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

>>> rtl/ied_front.sv
module ied_front #(
   parameter int COORD_WIDTH = ied_pkg::COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ied_pkg::stage_ctl_type          ctl_in,
   input  logic signed [COORD_WIDTH-1:0]   first_x,
   input  logic signed [COORD_WIDTH-1:0]   first_y,
   input  logic signed [COORD_WIDTH-1:0]   second_x,
   input  logic signed [COORD_WIDTH-1:0]   second_y,
   output logic                            valid_out,
   output logic [2*COORD_WIDTH+1:0]        sum_out
);
   localparam int DiffWidth = COORD_WIDTH + 1;
   localparam int SqWidth   = 2 * COORD_WIDTH + 2;

   logic signed [DiffWidth-1:0] dx;
   logic signed [DiffWidth-1:0] dy;
   logic [DiffWidth-1:0]        adx_in, ady_in, adx_ff, ady_ff;
   logic [SqWidth-1:0]          sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [SqWidth-1:0]          sum_in, sum_ff;
   logic [2:0]                  valid_ff;

   assign dx = {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
   assign dy = {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};

   assign adx_in = dx[DiffWidth-1] ? DiffWidth'(-dx) : DiffWidth'(dx);
   assign ady_in = dy[DiffWidth-1] ? DiffWidth'(-dy) : DiffWidth'(dy);

   assign sqx_in = SqWidth'(adx_ff) * SqWidth'(adx_ff);
   assign sqy_in = SqWidth'(ady_ff) * SqWidth'(ady_ff);

   assign sum_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.advance) begin
         valid_ff <= {valid_ff[1:0], ctl_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sum_ff <= sum_in;
      end
   end

   assign valid_out = valid_ff[2];
   assign sum_out   = sum_ff;
endmodule

>>> rtl/ied_sqrt_step.sv
module ied_sqrt_step #(
   parameter int ROOT_WIDTH = ied_pkg::COORD_WIDTH + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ied_pkg::stage_ctl_type     ctl_in,
   input  logic [2*ROOT_WIDTH-1:0]    rad_in,
   input  logic [ROOT_WIDTH+1:0]      rem_in,
   input  logic [ROOT_WIDTH-1:0]      root_in,
   output logic                       valid_out,
   output logic [2*ROOT_WIDTH-1:0]    rad_out,
   output logic [ROOT_WIDTH+1:0]      rem_out,
   output logic [ROOT_WIDTH-1:0]      root_out
);
   localparam int WorkWidth = ROOT_WIDTH + 4;

   logic [WorkWidth-1:0]      acc;
   logic [WorkWidth-1:0]      trial;
   logic                      take;
   logic                      valid_ff;
   logic [2*ROOT_WIDTH-1:0]   rad_ff;
   logic [ROOT_WIDTH+1:0]     rem_in_next, rem_ff;
   logic [ROOT_WIDTH-1:0]     root_in_next, root_ff;

   // One result bit per stage: bring down two radicand bits and try 4r+1.
   assign acc   = {rem_in, rad_in[2*ROOT_WIDTH-1 -: 2]};
   assign trial = {2'b00, root_in, 2'b01};
   assign take  = acc >= trial;

   assign rem_in_next  = take ? (ROOT_WIDTH+2)'(acc - trial) : (ROOT_WIDTH+2)'(acc);
   assign root_in_next = {root_in[ROOT_WIDTH-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl_in.advance) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         rad_ff  <= {rad_in[2*ROOT_WIDTH-3:0], 2'b00};
         rem_ff  <= rem_in_next;
         root_ff <= root_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
endmodule

>>> rtl/integer_euclidean_distance.sv
// Throughput: one transaction per cycle unless the response is stalled; the three front
// stages (difference, square, sum) are followed by one register stage per root bit.
// A stalled response freezes the whole pipeline, so nothing is lost or repeated.
// Reset is synchronous and active high; it clears the valid bits only.
module integer_euclidean_distance #(
   parameter int COORD_WIDTH = ied_pkg::COORD_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   ied_req_if.sink      req_chan,
   ied_rsp_if.source    rsp_chan
);
   localparam int RootWidth = COORD_WIDTH + 1;
   localparam int DistWidth = ied_pkg::DIST_WIDTH;

   ied_pkg::stage_ctl_type   front_ctl;
   logic                     advance;
   logic                     front_valid;
   logic [2*RootWidth-1:0]   front_sum;

   logic                     valid_w [RootWidth+1];
   logic [2*RootWidth-1:0]   rad_w   [RootWidth+1];
   logic [RootWidth+1:0]     rem_w   [RootWidth+1];
   logic [RootWidth-1:0]     root_w  [RootWidth+1];

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign front_ctl.advance = advance;
   assign front_ctl.valid   = req_chan.valid;

   ied_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (front_ctl),
      .first_x   (req_chan.first_x),
      .first_y   (req_chan.first_y),
      .second_x  (req_chan.second_x),
      .second_y  (req_chan.second_y),
      .valid_out (front_valid),
      .sum_out   (front_sum)
   );

   assign valid_w[0] = front_valid;
   assign rad_w[0]   = front_sum;
   assign rem_w[0]   = '0;
   assign root_w[0]  = '0;

   for (genvar k = 0; k < RootWidth; k++) begin : g_step
      ied_pkg::stage_ctl_type step_ctl;

      assign step_ctl.advance = advance;
      assign step_ctl.valid   = valid_w[k];

      ied_sqrt_step #(
         .ROOT_WIDTH (RootWidth)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (step_ctl),
         .rad_in    (rad_w[k]),
         .rem_in    (rem_w[k]),
         .root_in   (root_w[k]),
         .valid_out (valid_w[k+1]),
         .rad_out   (rad_w[k+1]),
         .rem_out   (rem_w[k+1]),
         .root_out  (root_w[k+1])
      );
   end

   assign rsp_chan.valid    = valid_w[RootWidth];
   assign rsp_chan.distance = DistWidth'(root_w[RootWidth]);
endmodule

>>> rtl/ied_checker.sv
module ied_checker #(
   parameter int DIST_WIDTH = ied_pkg::DIST_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DIST_WIDTH-1:0] rsp_distance
);

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("Stalled response changed.");

   // Requests are taken whenever the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request refused while the output is empty.");

   // The pipeline comes out of reset empty.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid straight after reset.");

   // A response only disappears through a completed transaction.
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("Response dropped without a transaction.");

endmodule

bind integer_euclidean_distance ied_checker #(
   .DIST_WIDTH (ied_pkg::DIST_WIDTH)
) u_ied_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_distance (rsp_chan.distance)
);
